### hdl/schm_pkg.sv
// Package for the sensor channel health monitor: register indexes, health codes,
// reset values and baseline limits. It has no dependencies.
package schm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LOW_RAIL      = 3'd0,
    REG_HIGH_RAIL     = 3'd1,
    REG_RAIL_CONFIRM  = 3'd2,
    REG_STILL_CONFIRM = 3'd3,
    REG_DRIFT_LIMIT   = 3'd4,
    REG_DRIFT_CONFIRM = 3'd5,
    REG_RANGE_CONFIRM = 3'd6
  } cfg_reg_e;

  // Health codes, listed in the order of their numeric value
  typedef enum logic [2:0] {
    HC_OK            = 3'd0,
    HC_BASE_INVALID  = 3'd1,
    HC_DRIFT         = 3'd2,
    HC_STUCK_LOW     = 3'd3,
    HC_STUCK_HIGH    = 3'd4,
    HC_NO_CHANGE     = 3'd5,
    HC_OUT_OF_CAL    = 3'd6,
    HC_UNKNOWN       = 3'd7
  } health_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_LOAD   = 1'b1
  } func_e;

  localparam int RAW_W  = 12;
  localparam int FIX_W  = 16;
  localparam int CHAN_W = 3;
  localparam int CFG_W  = 16;

  // Register reset values
  localparam logic [RAW_W-1:0] LOW_RAIL_RST      = 12'd5;
  localparam logic [RAW_W-1:0] HIGH_RAIL_RST     = 12'd4090;
  localparam logic [FIX_W-1:0] RAIL_CONFIRM_RST  = 16'd20;
  localparam logic [FIX_W-1:0] STILL_CONFIRM_RST = 16'd300;
  localparam logic [FIX_W-1:0] DRIFT_LIMIT_RST   = 16'd2400;  // 150.0 in Q12.4
  localparam logic [FIX_W-1:0] DRIFT_CONFIRM_RST = 16'd50;
  localparam logic [FIX_W-1:0] RANGE_CONFIRM_RST = 16'd100;

  // A baseline is valid between 20.0 and 4075.0, both included (Q12.4).
  localparam logic [FIX_W-1:0] BASE_MIN = 16'd320;
  localparam logic [FIX_W-1:0] BASE_MAX = 16'd65200;

  function automatic logic base_ok(input logic [FIX_W-1:0] b);
    return (b >= BASE_MIN) && (b <= BASE_MAX);
  endfunction

endpackage

### hdl/schm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module schm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sensor_channel_health_monitor.sv
// Sensor channel health monitor top level: per-channel record memory, health
// evaluation and frame flags. Uses schm_pkg and schm_ram.

// The block accepts one word per clock cycle while in_stall_o is low and
// returns one result word per accepted word, in order. Inside, the channel's
// record (baseline, previous raw value, valid-seen flag and five saturating run
// counters) is first read from a single synchronous RAM; then the record is
// updated, written back, and the health code and frame flags are registered
// onto the output. A result therefore passes the second-stage registers and
// then the output register before it shows on out_valid_o, and a receiver that
// does not stall takes it in the cycle in which it shows. Further words keep
// flowing while a result waits on out_stall_i until the second stage itself is
// blocked. A word that follows one for the same channel gets the just-written
// record forwarded, so back-to-back samples of one channel are counted
// correctly. Records start out cleared after reset by way of one valid flag per
// channel, so there is no clearing pass. Configuration writes take effect at
// once and are meant to happen only while no word is in flight.
module sensor_channel_health_monitor #(
  parameter int CHANNELS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_addr_i,
  input  logic [schm_pkg::CFG_W-1:0]    cfg_wdata_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [schm_pkg::CHAN_W-1:0]   channel_i,
  input  logic [schm_pkg::RAW_W-1:0]    raw_sample_i,
  input  logic [schm_pkg::FIX_W-1:0]    filtered_sample_i,
  input  logic                          seat_occupied_i,
  input  logic                          channel_active_i,
  input  logic                          in_calibration_i,
  input  logic [schm_pkg::FIX_W-1:0]    baseline_value_i,
  input  logic                          frame_end_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [schm_pkg::CHAN_W-1:0]   channel_out_o,
  output logic [2:0]                    health_code_o,
  output logic                          frame_all_ok_o,
  output logic                          frame_baselines_valid_o,
  output logic                          frame_last_o
);

  localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W   = (COUNT_BITS > schm_pkg::FIX_W) ? COUNT_BITS : schm_pkg::FIX_W;

  // One memory word holds everything the block remembers about a channel.
  typedef struct packed {
    logic [schm_pkg::FIX_W-1:0] baseline;
    logic [schm_pkg::RAW_W-1:0] prev_raw;
    logic                       prev_seen;
    logic [COUNT_BITS-1:0]      low_run;
    logic [COUNT_BITS-1:0]      high_run;
    logic [COUNT_BITS-1:0]      still_run;
    logic [COUNT_BITS-1:0]      drift_run;
    logic [COUNT_BITS-1:0]      range_run;
  } chan_rec_t;

  localparam int REC_W = $bits(chan_rec_t);

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic reached(input logic [COUNT_BITS-1:0] run,
                                   input logic [schm_pkg::FIX_W-1:0] confirm);
    return CMP_W'(run) >= CMP_W'(confirm);
  endfunction

  // Configuration registers
  logic [schm_pkg::RAW_W-1:0] low_rail_q, low_rail_d;
  logic [schm_pkg::RAW_W-1:0] high_rail_q, high_rail_d;
  logic [schm_pkg::FIX_W-1:0] rail_conf_q, rail_conf_d;
  logic [schm_pkg::FIX_W-1:0] still_conf_q, still_conf_d;
  logic [schm_pkg::FIX_W-1:0] drift_lim_q, drift_lim_d;
  logic [schm_pkg::FIX_W-1:0] drift_conf_q, drift_conf_d;
  logic [schm_pkg::FIX_W-1:0] range_conf_q, range_conf_d;

  always_comb begin
    low_rail_d   = low_rail_q;
    high_rail_d  = high_rail_q;
    rail_conf_d  = rail_conf_q;
    still_conf_d = still_conf_q;
    drift_lim_d  = drift_lim_q;
    drift_conf_d = drift_conf_q;
    range_conf_d = range_conf_q;
    if (cfg_we_i) begin
      case (schm_pkg::cfg_reg_e'(cfg_addr_i))
        schm_pkg::REG_LOW_RAIL:      low_rail_d   = cfg_wdata_i[schm_pkg::RAW_W-1:0];
        schm_pkg::REG_HIGH_RAIL:     high_rail_d  = cfg_wdata_i[schm_pkg::RAW_W-1:0];
        schm_pkg::REG_RAIL_CONFIRM:  rail_conf_d  = cfg_wdata_i;
        schm_pkg::REG_STILL_CONFIRM: still_conf_d = cfg_wdata_i;
        schm_pkg::REG_DRIFT_LIMIT:   drift_lim_d  = cfg_wdata_i;
        schm_pkg::REG_DRIFT_CONFIRM: drift_conf_d = cfg_wdata_i;
        schm_pkg::REG_RANGE_CONFIRM: range_conf_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_rail_q   <= schm_pkg::LOW_RAIL_RST;
      high_rail_q  <= schm_pkg::HIGH_RAIL_RST;
      rail_conf_q  <= schm_pkg::RAIL_CONFIRM_RST;
      still_conf_q <= schm_pkg::STILL_CONFIRM_RST;
      drift_lim_q  <= schm_pkg::DRIFT_LIMIT_RST;
      drift_conf_q <= schm_pkg::DRIFT_CONFIRM_RST;
      range_conf_q <= schm_pkg::RANGE_CONFIRM_RST;
    end else begin
      low_rail_q   <= low_rail_d;
      high_rail_q  <= high_rail_d;
      rail_conf_q  <= rail_conf_d;
      still_conf_q <= still_conf_d;
      drift_lim_q  <= drift_lim_d;
      drift_conf_q <= drift_conf_d;
      range_conf_q <= range_conf_d;
    end
  end

  // Handshake. The second stage moves on whenever the output register is free
  // or is being emptied in this cycle; the input stalls only when it cannot.
  logic s1_vld_q, s1_vld_d;
  logic out_vld_q, out_vld_d;
  logic s1_adv;
  logic in_accept;

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Record memory and write-back signals
  logic [CH_BITS-1:0] rd_addr;
  logic [REC_W-1:0]   rd_data;
  logic               wr_en;
  logic [CH_BITS-1:0] wr_addr;
  chan_rec_t          wr_rec;

  assign rd_addr = CH_BITS'(channel_i);

  schm_ram #(
    .WIDTH (REC_W),
    .DEPTH (CHANNELS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_rec),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // One flag per channel marks records written since reset; others read as zero.
  logic [CHANNELS-1:0] rec_valid_q, rec_valid_d;

  always_comb begin
    rec_valid_d = rec_valid_q;
    if (wr_en) begin
      rec_valid_d[wr_addr] = 1'b1;
    end
  end

  // Second-stage payload, loaded on accept
  logic                       s1_func_q;
  logic [schm_pkg::CHAN_W-1:0] s1_chan_q;
  logic [schm_pkg::RAW_W-1:0] s1_raw_q;
  logic [schm_pkg::FIX_W-1:0] s1_filt_q;
  logic                       s1_occ_q;
  logic                       s1_act_q;
  logic                       s1_cal_q;
  logic [schm_pkg::FIX_W-1:0] s1_base_q;
  logic                       s1_fend_q;
  // The record written at the accept edge is forwarded, since the memory read
  // at that same edge still returns the old contents.
  logic                       s1_hit_q;
  chan_rec_t                  s1_fwd_q;

  // Running frame flags
  logic run_ok_q, run_ok_d;
  logic run_base_q, run_base_d;

  // Output registers
  logic [schm_pkg::CHAN_W-1:0] out_chan_q;
  logic [2:0]                  out_code_q, out_code_d;
  logic                        out_all_ok_q, out_all_ok_d;
  logic                        out_base_ok_q, out_base_ok_d;
  logic                        out_last_q, out_last_d;

  // Evaluation of the word in the second stage
  logic               s1_in_range;
  logic [CH_BITS-1:0] s1_idx;
  chan_rec_t          cur_rec;
  chan_rec_t          new_rec;
  logic [schm_pkg::FIX_W:0] base_dist;
  logic               bvalid;
  schm_pkg::health_e  code;

  assign s1_in_range = 32'(s1_chan_q) < CHANNELS;
  assign s1_idx      = CH_BITS'(s1_chan_q);

  always_comb begin
    if (s1_hit_q) begin
      cur_rec = s1_fwd_q;
    end else if (s1_in_range && rec_valid_q[s1_idx]) begin
      cur_rec = chan_rec_t'(rd_data);
    end else begin
      cur_rec = '0;
    end

    if (s1_filt_q >= cur_rec.baseline) begin
      base_dist = {1'b0, s1_filt_q} - {1'b0, cur_rec.baseline};
    end else begin
      base_dist = {1'b0, cur_rec.baseline} - {1'b0, s1_filt_q};
    end
    bvalid = schm_pkg::base_ok(cur_rec.baseline);

    new_rec           = cur_rec;
    new_rec.low_run   = (s1_raw_q <= low_rail_q) ? bump(cur_rec.low_run) : '0;
    new_rec.high_run  = (s1_raw_q >= high_rail_q) ? bump(cur_rec.high_run) : '0;
    new_rec.still_run = (cur_rec.prev_seen && s1_raw_q == cur_rec.prev_raw)
                        ? bump(cur_rec.still_run) : '0;
    new_rec.prev_raw  = s1_raw_q;
    new_rec.prev_seen = 1'b1;
    new_rec.drift_run = (!s1_occ_q && base_dist > {1'b0, drift_lim_q})
                        ? bump(cur_rec.drift_run) : '0;
    new_rec.range_run = (s1_act_q && !s1_cal_q) ? bump(cur_rec.range_run) : '0;

    if (!bvalid) begin
      code = schm_pkg::HC_BASE_INVALID;
    end else if (reached(new_rec.low_run, rail_conf_q)) begin
      code = schm_pkg::HC_STUCK_LOW;
    end else if (reached(new_rec.high_run, rail_conf_q)) begin
      code = schm_pkg::HC_STUCK_HIGH;
    end else if (reached(new_rec.drift_run, drift_conf_q)) begin
      code = schm_pkg::HC_DRIFT;
    end else if (reached(new_rec.still_run, still_conf_q)) begin
      code = schm_pkg::HC_NO_CHANGE;
    end else if (reached(new_rec.range_run, range_conf_q)) begin
      code = schm_pkg::HC_OUT_OF_CAL;
    end else begin
      code = schm_pkg::HC_OK;
    end
  end

  // Write-back, result and frame flag update
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = s1_idx;
    wr_rec        = new_rec;
    run_ok_d      = run_ok_q;
    run_base_d    = run_base_q;
    out_code_d    = out_code_q;
    out_all_ok_d  = out_all_ok_q;
    out_base_ok_d = out_base_ok_q;
    out_last_d    = out_last_q;

    if (s1_adv) begin
      if (s1_func_q == schm_pkg::FUNC_LOAD) begin
        // A load replaces the baseline and clears the history of the channel.
        wr_en           = s1_in_range;
        wr_rec          = '0;
        wr_rec.baseline = s1_base_q;
        out_code_d      = (s1_in_range && !schm_pkg::base_ok(s1_base_q))
                          ? schm_pkg::HC_BASE_INVALID : schm_pkg::HC_UNKNOWN;
        out_all_ok_d    = run_ok_q;
        out_base_ok_d   = run_base_q;
        out_last_d      = 1'b0;
      end else begin
        wr_en         = s1_in_range;
        out_code_d    = s1_in_range ? code : schm_pkg::HC_UNKNOWN;
        out_all_ok_d  = run_ok_q && s1_in_range && (code == schm_pkg::HC_OK);
        out_base_ok_d = run_base_q && (!s1_in_range || bvalid);
        out_last_d    = s1_fend_q;
        if (s1_fend_q) begin
          run_ok_d   = 1'b1;
          run_base_d = 1'b1;
        end else begin
          run_ok_d   = out_all_ok_d;
          run_base_d = out_base_ok_d;
        end
      end
    end
  end

  always_comb begin
    if (in_accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end else begin
      s1_vld_d = s1_vld_q;
    end

    if (s1_adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      rec_valid_q <= '0;
      run_ok_q    <= 1'b1;
      run_base_q  <= 1'b1;
    end else begin
      s1_vld_q    <= s1_vld_d;
      out_vld_q   <= out_vld_d;
      rec_valid_q <= rec_valid_d;
      run_ok_q    <= run_ok_d;
      run_base_q  <= run_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_i;
      s1_chan_q <= channel_i;
      s1_raw_q  <= raw_sample_i;
      s1_filt_q <= filtered_sample_i;
      s1_occ_q  <= seat_occupied_i;
      s1_act_q  <= channel_active_i;
      s1_cal_q  <= in_calibration_i;
      s1_base_q <= baseline_value_i;
      s1_fend_q <= frame_end_i;
      s1_hit_q  <= wr_en && (wr_addr == rd_addr);
      s1_fwd_q  <= wr_rec;
    end
    if (s1_adv) begin
      out_chan_q <= s1_chan_q;
    end
    out_code_q    <= out_code_d;
    out_all_ok_q  <= out_all_ok_d;
    out_base_ok_q <= out_base_ok_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o             = out_vld_q;
  assign channel_out_o           = out_chan_q;
  assign health_code_o           = out_code_q;
  assign frame_all_ok_o          = out_all_ok_q;
  assign frame_baselines_valid_o = out_base_ok_q;
  assign frame_last_o            = out_last_q;

endmodule
